// ----- sv/piano_note_voice_synth_core_macros.svh -----
// Assertion helpers used by the checker file.
// Both sample on clk and stand down while arst_n is low.
`ifndef PIANO_NOTE_VOICE_SYNTH_CORE_MACROS_SVH
`define PIANO_NOTE_VOICE_SYNTH_CORE_MACROS_SVH

// Same-cycle implication
`define PNVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PNVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/pnvs_pkg.sv -----
package pnvs_pkg;

	// Field and state widths
	localparam int PHASE_BITS = 24;
	localparam int STEP_BITS = 24;
	localparam int IN_DATA_BITS = ((STEP_BITS + 7) / 8) * 8;
	localparam int COUNT_BITS = 20;
	localparam int WHOLE_BITS = 8;
	localparam int CYC_BITS = WHOLE_BITS + 1;
	localparam int SUST_BITS = 19;
	localparam int REL_BITS = 19;
	localparam int TOT_BITS = REL_BITS + 1;
	localparam int PEAK_BITS = 14;
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS = SAMPLE_BITS + 3;

	// Fixed-point formats: Q1.15 sine table, Q0.15 decay table, Q14.16 volume
	localparam int Q_BITS = 15;
	localparam int VOL_FRAC = 16;
	localparam int VOL_BITS = PEAK_BITS + VOL_FRAC;
	localparam int MUL_A_BITS = VOL_BITS;
	localparam int MUL_B_BITS = Q_BITS;
	localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int MAG_SHIFT = VOL_FRAC + Q_BITS;

	// Volume divider: one quotient bit per cycle
	localparam int DIV_STEPS = VOL_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	// Tables
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
	localparam int DECAY_DEPTH = 256;
	localparam int DECAY_IDX_BITS = $clog2(DECAY_DEPTH);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] DECAY_RATIO_Q30 = 64'd572828476;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	// Configuration port
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 19;
	localparam logic [SUST_BITS-1:0] SUSTAIN_RESET = SUST_BITS'(11025);
	localparam logic [REL_BITS-1:0] RELEASE_RESET = REL_BITS'(44100);
	localparam logic [PEAK_BITS-1:0] PEAK_RESET = PEAK_BITS'(6000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SUSTAIN = 2'd0,
		CFG_RELEASE = 2'd1,
		CFG_PEAK    = 2'd2
	} cfg_idx_t;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_VOL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_LOOK,
		OP_SQ,
		OP_CUBE,
		OP_VC,
		OP_AE,
		OP_TONE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   tone2;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic in_sustain;
		logic out_free;
	} dp_status_t;

	typedef logic [SAMPLE_BITS-1:0] sine_rom_t [SINE_DEPTH];
	typedef logic [Q_BITS-1:0] decay_rom_t [DECAY_DEPTH];

	// One full sine period, Q1.15, from a quarter-wave Taylor series in Q30
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] quad, rem, x, sum, t, v;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			quad = 64'(k) >> (SINE_IDX_BITS - 2);
			rem = (64'(k) << 2) % SINE_DEPTH;
			if (quad[0])
				rem = 64'(SINE_DEPTH) - rem;
			x = rem * HALF_PI_Q30 / SINE_DEPTH;
			sum = x;
			t = x;
			for (int n = 0; n < 6; n++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / TAYLOR_DIV[n];
				if (n[0] == 1'b0)
					sum = sum - t;
				else
					sum = sum + t;
			end
			v = (sum + 64'd16384) >> 15;
			if (v > 64'd32767)
				v = 64'd32767;
			rom[k] = (quad >= 64'd2) ? SAMPLE_BITS'(64'd0 - v) : SAMPLE_BITS'(v);
		end
		return rom;
	endfunction

	// r^n in Q0.15, power carried in Q30 with half-up rounding
	function automatic decay_rom_t build_decay_rom();
		decay_rom_t rom;
		logic [63:0] d, v;
		d = 64'd1 << 30;
		for (int n = 0; n < DECAY_DEPTH; n++) begin
			v = (d + 64'd16384) >> 15;
			rom[n] = (v > 64'd32767) ? Q_BITS'(32767) : Q_BITS'(v);
			d = (d * DECAY_RATIO_Q30 + 64'd536870912) >> 30;
		end
		return rom;
	endfunction

endpackage

// ----- sv/pnvs_ctrl.sv -----
module pnvs_ctrl import pnvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_mode,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_VOL      = 12'b0000_0000_0010,
		ST_DIV_INIT = 12'b0000_0000_0100,
		ST_DIV      = 12'b0000_0000_1000,
		ST_DIV_DONE = 12'b0000_0001_0000,
		ST_LOOK     = 12'b0000_0010_0000,
		ST_SQ       = 12'b0000_0100_0000,
		ST_CUBE     = 12'b0000_1000_0000,
		ST_VC       = 12'b0001_0000_0000,
		ST_AE       = 12'b0010_0000_0000,
		ST_TONE     = 12'b0100_0000_0000,
		ST_OUT      = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;
	logic tone2_q, tone2_d;

	always_comb begin
		state_d = state_q;
		div_cnt_d = div_cnt_q;
		tone2_d = tone2_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.tone2 = tone2_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode == MODE_START)
						cmd.op = OP_START;
					else if (status.active)
						state_d = ST_VOL;
				end
			end
			ST_VOL: begin
				cmd.op = OP_VOL;
				tone2_d = 1'b0;
				state_d = status.in_sustain ? ST_LOOK : ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.op = OP_DIV_INIT;
				div_cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				div_cnt_d = div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1))
					state_d = ST_DIV_DONE;
			end
			ST_DIV_DONE: begin
				cmd.op = OP_DIV_DONE;
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.op = OP_LOOK;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				state_d = ST_CUBE;
			end
			ST_CUBE: begin
				cmd.op = OP_CUBE;
				state_d = ST_VC;
			end
			ST_VC: begin
				cmd.op = OP_VC;
				state_d = ST_AE;
			end
			ST_AE: begin
				cmd.op = OP_AE;
				state_d = ST_TONE;
			end
			ST_TONE: begin
				cmd.op = OP_TONE;
				if (tone2_q) begin
					state_d = ST_OUT;
				end else begin
					tone2_d = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_OUT: begin
				// hold the finished sample until the output register frees up
				if (status.out_free) begin
					cmd.op = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
			tone2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_cnt_q <= div_cnt_d;
			tone2_q <= tone2_d;
		end
	end

endmodule

// ----- sv/pnvs_datapath.sv -----
module pnvs_datapath import pnvs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_status_t               status,
	input  logic [IN_DATA_BITS-1:0]  in_step,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [SAMPLE_BITS-1:0]   out_data,
	output logic                     out_last
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam decay_rom_t DECAY_ROM = build_decay_rom();

	// configuration
	logic [SUST_BITS-1:0] sustain_q;
	logic [REL_BITS-1:0] release_q;
	logic [PEAK_BITS-1:0] peak_q;

	// note state
	logic [COUNT_BITS-1:0] count_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [WHOLE_BITS-1:0] whole_q;
	logic [PHASE_BITS-1:0] step_q;
	logic active_q;

	// working registers
	logic [VOL_BITS-1:0] vol_q;
	logic [PROD_BITS-1:0] p_q, acc_q;
	logic [REL_BITS-1:0] rem_q;
	logic [VOL_BITS-1:0] dq_q;
	logic [SAMPLE_BITS-1:0] s_rd_q;
	logic [Q_BITS-1:0] d_rd_q, a_q, e_q;
	logic neg_q;
	logic [SAMPLE_BITS-1:0] t1_q, t2_q;
	logic out_valid_q, out_last_q;
	logic [SAMPLE_BITS-1:0] out_data_q;

	// combinational
	logic [REL_BITS-1:0] rel;
	logic [COUNT_BITS-1:0] past, rel_ext;
	logic [REL_BITS-1:0] left;
	logic [MUL_A_BITS-1:0] mul_a;
	logic [MUL_B_BITS-1:0] mul_b;
	logic [PROD_BITS-1:0] mul_p;
	logic [REL_BITS:0] rem_sh;
	logic div_ge;
	logic [PHASE_BITS-1:0] look_phase;
	logic [CYC_BITS-1:0] look_cyc;
	logic [SINE_IDX_BITS-1:0] look_idx;
	logic [SAMPLE_BITS-1:0] abs_full;
	logic [Q_BITS-1:0] abs_s;
	logic [PROD_BITS:0] mag_sum;
	logic [SAMPLE_BITS-1:0] mag_ext, tone_val;
	logic [SUM_BITS-1:0] mix, mix_adj, mix_q;
	logic mix_sat;
	logic [SAMPLE_BITS-1:0] sample_val;
	logic [TOT_BITS-1:0] total;
	logic [COUNT_BITS:0] next_idx;
	logic last;
	logic [PHASE_BITS:0] phase_sum;

	// volume terms
	assign rel = (release_q == '0) ? REL_BITS'(1) : release_q;
	assign rel_ext = COUNT_BITS'(rel);
	assign past = count_q - COUNT_BITS'(sustain_q);
	assign left = (past < rel_ext) ? REL_BITS'(rel_ext - past) : '0;

	// restoring divider step
	assign rem_sh = {rem_q, dq_q[VOL_BITS-1]};
	assign div_ge = rem_sh >= {1'b0, rel};

	// table addressing: second tone runs at twice the phase
	assign look_phase = cmd.tone2 ? {phase_q[PHASE_BITS-2:0], 1'b0} : phase_q;
	assign look_cyc = cmd.tone2 ? {whole_q, phase_q[PHASE_BITS-1]} : CYC_BITS'(whole_q);
	assign look_idx = look_phase[PHASE_BITS-1 -: SINE_IDX_BITS];

	assign abs_full = s_rd_q[SAMPLE_BITS-1] ? (~s_rd_q + 1'b1) : s_rd_q;
	assign abs_s = abs_full[Q_BITS-1:0];

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_VOL: begin
				mul_a = MUL_A_BITS'(left);
				mul_b = MUL_B_BITS'(peak_q);
			end
			OP_SQ: begin
				mul_a = MUL_A_BITS'(abs_s);
				mul_b = abs_s;
			end
			OP_CUBE: begin
				mul_a = MUL_A_BITS'(p_q[2*Q_BITS-1:0]);
				mul_b = a_q;
			end
			OP_VC: begin
				mul_a = vol_q;
				mul_b = p_q[2*Q_BITS +: Q_BITS];
			end
			OP_AE: begin
				mul_a = MUL_A_BITS'(e_q);
				mul_b = a_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

	// (vol*cube + 2*a*decay) >> 31, sign of the sine applied after
	assign mag_sum = {1'b0, acc_q} + {p_q, 1'b0};
	assign mag_ext = SAMPLE_BITS'(mag_sum[MAG_SHIFT +: Q_BITS]);
	assign tone_val = neg_q ? (~mag_ext + 1'b1) : mag_ext;

	// (4*t1 + t2) / 4 toward zero, then saturate
	assign mix = {t1_q[SAMPLE_BITS-1], t1_q, 2'b00}
		+ {{3{t2_q[SAMPLE_BITS-1]}}, t2_q};
	assign mix_adj = mix + (mix[SUM_BITS-1] ? SUM_BITS'(3) : '0);
	assign mix_q = {{2{mix_adj[SUM_BITS-1]}}, mix_adj[SUM_BITS-1:2]};
	assign mix_sat = mix_q[SUM_BITS-1:SAMPLE_BITS-1]
		!= {(SUM_BITS - SAMPLE_BITS + 1){mix_q[SUM_BITS-1]}};
	assign sample_val = mix_sat
		? {mix_q[SUM_BITS-1], {(SAMPLE_BITS-1){~mix_q[SUM_BITS-1]}}}
		: mix_q[SAMPLE_BITS-1:0];

	assign total = TOT_BITS'(sustain_q) + TOT_BITS'(rel);
	assign next_idx = {1'b0, count_q} + 1'b1;
	assign last = (next_idx >= (COUNT_BITS + 1)'(total)) || (count_q == '1);
	assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sustain_q <= SUSTAIN_RESET;
			release_q <= RELEASE_RESET;
			peak_q <= PEAK_RESET;
			count_q <= '0;
			phase_q <= '0;
			whole_q <= '0;
			step_q <= '0;
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SUSTAIN: sustain_q <= SUST_BITS'(cfg_data);
					CFG_RELEASE: release_q <= REL_BITS'(cfg_data);
					CFG_PEAK:    peak_q <= PEAK_BITS'(cfg_data);
					default: ;
				endcase
			end
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.op == OP_START) begin
				step_q <= in_step[PHASE_BITS-1:0];
				count_q <= '0;
				phase_q <= '0;
				whole_q <= '0;
				active_q <= 1'b1;
			end
			if (cmd.op == OP_OUT) begin
				phase_q <= phase_sum[PHASE_BITS-1:0];
				if (phase_sum[PHASE_BITS] && whole_q != '1)
					whole_q <= whole_q + 1'b1;
				if (count_q != '1)
					count_q <= count_q + 1'b1;
				if (last)
					active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_VOL: begin
				vol_q <= VOL_BITS'(peak_q) << VOL_FRAC;
				p_q <= mul_p;
			end
			OP_DIV_INIT: begin
				// the top bits of peak*left*2^16 are known to sit below rel
				rem_q <= p_q[PEAK_BITS +: REL_BITS];
				dq_q <= {p_q[PEAK_BITS-1:0], {VOL_FRAC{1'b0}}};
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? REL_BITS'(rem_sh - {1'b0, rel}) : REL_BITS'(rem_sh);
				dq_q <= {dq_q[VOL_BITS-2:0], div_ge};
			end
			OP_DIV_DONE: begin
				vol_q <= dq_q;
			end
			OP_LOOK: begin
				s_rd_q <= SINE_ROM[look_idx];
				d_rd_q <= (32'(look_cyc) < DECAY_DEPTH)
					? DECAY_ROM[DECAY_IDX_BITS'(look_cyc)] : '0;
			end
			OP_SQ: begin
				a_q <= abs_s;
				neg_q <= s_rd_q[SAMPLE_BITS-1];
				e_q <= d_rd_q;
				p_q <= mul_p;
			end
			OP_CUBE: begin
				p_q <= mul_p;
			end
			OP_VC: begin
				p_q <= mul_p;
			end
			OP_AE: begin
				acc_q <= p_q;
				p_q <= mul_p;
			end
			OP_TONE: begin
				if (cmd.tone2)
					t2_q <= tone_val;
				else
					t1_q <= tone_val;
			end
			OP_OUT: begin
				out_data_q <= sample_val;
				out_last_q <= last;
			end
			default: ;
		endcase
	end

	assign status.active = active_q;
	assign status.in_sustain = count_q < COUNT_BITS'(sustain_q);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;

endmodule

// ----- sv/piano_note_voice_synth_core.sv -----
// Start item: accepted with no result; the core is still ready the next cycle.
// Tick in sustain: volume, then per tone look, square, cube, scale, decay, tone; then output.
// Tick in release: the 30-step bit-serial volume divider runs between the volume and look-up steps.
// Rate is set by the single shared 30x15 multiplier (one volume product, four per tone, two tones).
// Reset (arst_n low, asynchronous): note state cleared, config to defaults, no clear pass.
module piano_note_voice_synth_core import pnvs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // [23:0] phase_step
	input  logic                     s_axis_tuser,  // [0] mode
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [SAMPLE_BITS-1:0]   m_axis_tdata,  // [15:0] sample
	output logic                     m_axis_tlast,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	pnvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pnvs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_step   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- sv/pnvs_checker.sv -----
`include "piano_note_voice_synth_core_macros.svh"

module pnvs_checker import pnvs_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [SAMPLE_BITS-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	// stalled result must hold
	`PNVS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

	// a note start never occupies the block
	`PNVS_ASSERT_NEXT(a_start_keeps_ready, s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_START), s_axis_tready, "busy after note start transaction")

	// a new sample only appears after the tone sequence has run
	`PNVS_ASSERT_NOW(a_sample_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready, 12), "sample produced without full computation")

endmodule

bind piano_note_voice_synth_core pnvs_checker u_pnvs_checker (.*);
